### rtl/sorted_value_list_macros.svh
// Assertion macros shared by the sorted value list RTL.
// Used by files that check their own logic; no other dependencies.
`ifndef SORTED_VALUE_LIST_MACROS_SVH
`define SORTED_VALUE_LIST_MACROS_SVH
`ifndef SYNTH
// Invariant that must hold at every clock edge outside reset.
`define SVL_ASSERT(lbl, clk_sig, rstn_sig, cond, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (cond)) else $error(msg);
// Implication: when the antecedent holds, the consequent must follow.
`define SVL_ASSERT_IMPL(lbl, clk_sig, rstn_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
	else $error(msg);
`else
`define SVL_ASSERT(lbl, clk_sig, rstn_sig, cond, msg)
`define SVL_ASSERT_IMPL(lbl, clk_sig, rstn_sig, ante, cons, msg)
`endif
`endif

### rtl/svl_pkg.sv
// Package for the sorted value list: field widths, operation and status codes,
// and the structs passed between the top level and the cells. No dependencies.
`timescale 1ns / 1ps
package svl_pkg;

	// Fixed widths of the channel fields.
	localparam int ITEM_BITS   = 32;
	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	// Operation codes; the unused code is treated as a query.
	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} svl_op_t;

	// Result status codes.
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} svl_status_t;

	// Controller states.
	typedef enum logic {
		SVL_IDLE,
		SVL_EXEC
	} svl_state_t;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} svl_cmd_t;

	// Compare flags reported by each cell.
	typedef struct packed {
		logic le;
		logic lt;
		logic eq;
	} svl_flags_t;

endpackage

### rtl/svl_if.sv
// Valid/ready channel interfaces for the sorted value list.
// Depends on svl_pkg for field widths.
`timescale 1ns / 1ps
interface svl_req_if import svl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_BITS-1:0]   operation;
	logic [ITEM_BITS-1:0] item_value;

	modport source (output valid, output operation, output item_value, input ready);
	modport sink (input valid, input operation, input item_value, output ready);
endinterface

interface svl_rsp_if import svl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [STATUS_BITS-1:0] status;
	logic [COUNT_BITS-1:0]  entry_count;

	modport source (output valid, output hit, output status, output entry_count, input ready);
	modport sink (input valid, input hit, input status, input entry_count, output ready);
endinterface

### rtl/svl_cell.sv
// One cell of the sorted value list: holds one entry, compares it with the
// broadcast value and shifts in from a neighbor. Depends on svl_pkg.
`timescale 1ns / 1ps
module svl_cell import svl_pkg::*; #(
	parameter int VB = 32
) (
	input  logic          clk,
	input  svl_cmd_t      cmd,
	input  logic [VB-1:0] value,
	input  logic          occupied,
	input  logic          left_le,
	input  logic [VB-1:0] left_entry,
	input  logic [VB-1:0] right_entry,
	output logic [VB-1:0] entry,
	output svl_flags_t    flags
);

	logic [VB-1:0] entry_q;

	// Compare the held entry against the broadcast value.
	always_comb begin
		flags.le = occupied && (entry_q <= value);
		flags.lt = occupied && (entry_q < value);
		flags.eq = occupied && (entry_q == value);
	end

	// Insert: cells past the insertion point take the new value or shift right.
	// Remove: cells at and after the first equal entry shift left.
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (!flags.le) begin
				entry_q <= left_le ? value : left_entry;
			end
		end else if (cmd.rem_en) begin
			if (!flags.lt) begin
				entry_q <= right_entry;
			end
		end
	end

	assign entry = entry_q;

endmodule

### rtl/sorted_value_list.sv
// Sorted value list: keeps up to CAPACITY unsigned values in ascending order,
// duplicates allowed, in a row of cells that each hold one entry.
// Channels: req carries a word of operation (insert, remove first equal
// entry, query; the unused code acts as a query) and item_value. rsp carries
// one word per request: hit, status (ok, not found, full) and entry_count
// after the operation.
// Timing: an accepted request is held in the request register, and the row
// of cells compares and shifts in the cycle after acceptance, as does the
// loading of the response register. No new request is taken until that
// compare-and-shift across the whole row is done.
// An insert lands after any equal entries; an insert into a full list is
// refused with status full and leaves the list unchanged.
// Reset: arst_n clears the entry count and the controller; entry contents
// are left as they are and need no clearing pass.
// Stall: a response waits in the output register until rsp.ready; the next
// request is taken in the same cycle the waiting response is taken.
`timescale 1ns / 1ps
`include "sorted_value_list_macros.svh"
module sorted_value_list import svl_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	svl_req_if.sink   req,
	svl_rsp_if.source rsp
);

	localparam int VB = (VALUE_BITS < ITEM_BITS) ? VALUE_BITS : ITEM_BITS;
	localparam int CW = $clog2(CAPACITY + 1);

	svl_state_t             state_q, state_d;
	logic                   exec;
	logic                   accept;
	logic [OP_BITS-1:0]     op_q;
	logic [VB-1:0]          value_q;
	logic [CW-1:0]          count_q, count_d;
	logic                   full;
	logic                   found;
	logic                   is_insert, is_remove;
	svl_cmd_t               cmd;
	logic                   out_valid_q;
	logic                   hit_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [COUNT_BITS-1:0]  count_out_q, count_ext;
	svl_status_t            status_d;
	logic                   hit_d;

	logic [VB-1:0]          entries [CAPACITY];
	svl_flags_t             flags   [CAPACITY];
	logic [CAPACITY-1:0]    eq_vec;

	// Controller next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SVL_IDLE: begin
				if (accept) begin
					state_d = SVL_EXEC;
				end
			end
			SVL_EXEC: begin
				state_d = SVL_IDLE;
			end
			default: begin
				state_d = SVL_IDLE;
			end
		endcase
	end

	// Controller outputs.
	always_comb begin
		req.ready = 1'b0;
		exec      = 1'b0;
		case (state_q)
			SVL_IDLE: begin
				req.ready = !out_valid_q || rsp.ready;
			end
			SVL_EXEC: begin
				exec = 1'b1;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SVL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request word.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			value_q <= req.item_value[VB-1:0];
		end
	end

	// Row of cells with neighbor links.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic          occ;
		logic          l_le;
		logic [VB-1:0] l_entry;
		logic [VB-1:0] r_entry;

		assign occ = CW'(i) < count_q;
		if (i == 0) begin : g_first
			assign l_le    = 1'b1;
			assign l_entry = value_q;
		end else begin : g_mid
			assign l_le    = flags[i-1].le;
			assign l_entry = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign r_entry = entries[i];
		end else begin : g_inner
			assign r_entry = entries[i+1];
		end

		svl_cell #(
			.VB(VB)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (value_q),
			.occupied   (occ),
			.left_le    (l_le),
			.left_entry (l_entry),
			.right_entry(r_entry),
			.entry      (entries[i]),
			.flags      (flags[i])
		);

		assign eq_vec[i] = flags[i].eq;
	end

	// Decode and broadcast the update command.
	assign full      = count_q == CW'(CAPACITY);
	assign found     = |eq_vec;
	assign is_insert = op_q == OP_INSERT;
	assign is_remove = op_q == OP_REMOVE;

	always_comb begin
		cmd.ins_en = exec && is_insert && !full;
		cmd.rem_en = exec && is_remove && found;
	end

	// Next entry count and result fields.
	always_comb begin
		count_d  = count_q;
		hit_d    = 1'b0;
		status_d = ST_OK;
		if (is_insert) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else if (found) begin
			hit_d = 1'b1;
			if (is_remove) begin
				count_d = count_q - CW'(1);
			end
		end else begin
			status_d = ST_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec) begin
			count_q <= count_d;
		end
	end

	// Fit the count to the response field.
	if (CW >= COUNT_BITS) begin : g_cnt_trunc
		assign count_ext = count_d[COUNT_BITS-1:0];
	end else begin : g_cnt_ext
		assign count_ext = {{(COUNT_BITS - CW){1'b0}}, count_d};
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_q       <= hit_d;
			status_q    <= status_d;
			count_out_q <= count_ext;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_out_q;

	// Checks on the controller and entry count.
	`SVL_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY), "entry count over capacity")
	`SVL_ASSERT(a_exec_free_out, clk, arst_n, !(exec && out_valid_q), "execute with response pending")
	`SVL_ASSERT_IMPL(a_accept_exec, clk, arst_n, accept, ##1 exec, "accepted word not executed")
	`SVL_ASSERT_IMPL(a_exec_rsp, clk, arst_n, exec, ##1 out_valid_q, "execute produced no response")
	`SVL_ASSERT_IMPL(a_insert_grows, clk, arst_n, cmd.ins_en, ##1 (count_q == $past(count_q) + CW'(1)), "insert did not grow count")

endmodule

### bench/sorted_value_list_tb.sv
// Self-checking testbench for the sorted value list: a randomized valid/ready driver and
// monitor around one instance, with a behavioral sorted store predicting every response word.
// Depends on svl_pkg, the svl_req_if/svl_rsp_if interfaces and the sorted_value_list RTL.
`timescale 1ns / 1ps
module sorted_value_list_tb;
	import svl_pkg::*;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int STALL_MAX  = 14;
	localparam int IDLE_LIMIT = 500;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_WORDS  = 1650;

	// The fourth operation code is not in the package; the block decodes it as a query.
	localparam logic [OP_BITS-1:0] OP_RESERVED = 2'd3;
	localparam logic [ITEM_BITS-1:0] VALUE_MASK = {ITEM_BITS{1'b1}} >> (ITEM_BITS - VALUE_BITS);
	localparam logic [ITEM_BITS-1:0] VALUE_TOP  = {ITEM_BITS{1'b1}};

	typedef struct {
		logic [OP_BITS-1:0]   operation;
		logic [ITEM_BITS-1:0] item_value;
		int                   gap;
		bit                   drain;
	} op_word_t;

	typedef struct packed {
		logic                  hit;
		svl_status_t           status;
		logic [COUNT_BITS-1:0] entry_count;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	svl_req_if req ();
	svl_rsp_if rsp ();

	sorted_value_list #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the sorted store and its fill level.
	logic [ITEM_BITS-1:0] shadow_entries [CAPACITY];
	int unsigned          shadow_count = 0;

	op_word_t  pending_words [$];
	list_rsp_t expected_rsp [$];
	op_word_t  next_word;
	bit        have_next;
	int        hold_left;
	int        sent_cnt;
	int        done_cnt;
	int        stall_left;
	bit        rsp_quiet;
	int        mismatch_cnt = 0;
	int        idle_cycles = 0;

	task automatic report_mismatch(string what);
		mismatch_cnt++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	// Apply one operation to the shadow store and queue the response it should produce.
	function automatic void apply_list_op(logic [OP_BITS-1:0] op_code,
			logic [ITEM_BITS-1:0] raw_value);
		list_rsp_t            r;
		logic [ITEM_BITS-1:0] v;
		int                   match_at;
		int                   pos;
		int                   k;
		v = raw_value & VALUE_MASK;
		r.hit = 1'b0;
		r.status = ST_OK;
		match_at = shadow_count;
		for (k = shadow_count - 1; k >= 0; k--) begin
			if (shadow_entries[k] == v)
				match_at = k;
		end
		case (op_code)
			OP_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// New value lands after every entry equal to it.
					pos = 0;
					while (pos < shadow_count && shadow_entries[pos] <= v)
						pos++;
					for (k = shadow_count; k > pos; k--)
						shadow_entries[k] = shadow_entries[k - 1];
					shadow_entries[pos] = v;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (match_at < shadow_count) begin
					for (k = match_at; k + 1 < shadow_count; k++)
						shadow_entries[k] = shadow_entries[k + 1];
					shadow_count--;
					r.hit = 1'b1;
				end else begin
					r.status = ST_MISSING;
				end
			end
			default: begin
				// Query and the reserved code behave alike.
				if (match_at < shadow_count)
					r.hit = 1'b1;
				else
					r.status = ST_MISSING;
			end
		endcase
		r.entry_count = shadow_count[COUNT_BITS-1:0];
		expected_rsp.push_back(r);
	endfunction

	function automatic void queue_word(logic [OP_BITS-1:0] op_code,
			logic [ITEM_BITS-1:0] value, int gap, bit drain);
		op_word_t w;
		w.operation = op_code;
		w.item_value = value;
		w.gap = gap;
		w.drain = drain;
		pending_words.push_back(w);
	endfunction

	// Request driver: holds a word until accepted, then waits out the next word's gap.
	always @(posedge clk or negedge arst_n) begin
		bit taken;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= OP_INSERT;
			req.item_value <= '0;
			have_next = 1'b0;
			hold_left = 0;
			sent_cnt <= 0;
		end else begin
			taken = req.valid && req.ready;
			if (taken) begin
				apply_list_op(req.operation, req.item_value);
				sent_cnt <= sent_cnt + 1;
			end
			if (taken || !req.valid) begin
				if (!have_next && pending_words.size() > 0) begin
					next_word = pending_words.pop_front();
					have_next = 1'b1;
					hold_left = next_word.gap;
				end
				// A draining word also waits until every response has come back.
				if (have_next && hold_left == 0 &&
						(!next_word.drain || (!taken && sent_cnt == done_cnt))) begin
					req.valid <= 1'b1;
					req.operation <= next_word.operation;
					req.item_value <= next_word.item_value;
					have_next = 1'b0;
				end else begin
					req.valid <= 1'b0;
					if (have_next && hold_left > 0)
						hold_left--;
				end
			end
		end
	end

	// Response monitor: random back-pressure and a field-by-field check of each word.
	always @(posedge clk or negedge arst_n) begin
		list_rsp_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
			rsp_quiet = 1'b0;
			done_cnt <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				done_cnt <= done_cnt + 1;
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("response %0d arrived with no request outstanding",
						done_cnt));
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.hit !== want.hit)
						report_mismatch($sformatf("response %0d: hit %b, expected %b",
							done_cnt, rsp.hit, want.hit));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("response %0d: status %0d, expected %0d",
							done_cnt, rsp.status, want.status));
					if (rsp.entry_count !== want.entry_count)
						report_mismatch($sformatf("response %0d: entry_count %0d, expected %0d",
							done_cnt, rsp.entry_count, want.entry_count));
				end
				// Stretches of full-rate acceptance alternate with random stalls.
				if (done_cnt % 50 == 0)
					rsp_quiet = ($urandom_range(0, 2) == 0);
				stall_left = rsp_quiet ? 0 : $urandom_range(0, STALL_MAX);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp.ready <= (stall_left == 0);
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("sorted_value_list verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [ITEM_BITS-1:0] pool [6];
		logic [ITEM_BITS-1:0] v;
		logic [OP_BITS-1:0]   op_code;
		int                   made;
		int                   phase_kind;
		int                   ins_pct;
		int                   rem_pct;
		int                   roll;
		int                   gap;
		bit                   tx_quiet;
		int                   j;
		int                   k;

		arst_n = 1'b0;

		// Directed: empty store, extremes, duplicates, reserved code, missing value.
		queue_word(OP_REMOVE, 32'd5, 0, 1'b0);
		queue_word(OP_QUERY, 32'd0, 0, 1'b0);
		queue_word(OP_INSERT, VALUE_TOP, 0, 1'b0);
		queue_word(OP_INSERT, 32'd0, 0, 1'b0);
		queue_word(OP_INSERT, 32'd0, 0, 1'b0);
		queue_word(OP_INSERT, 32'h8000_0000, 0, 1'b0);
		queue_word(OP_QUERY, 32'd0, 0, 1'b0);
		queue_word(OP_RESERVED, 32'h8000_0000, 0, 1'b0);
		queue_word(OP_RESERVED, 32'd7, 0, 1'b0);
		queue_word(OP_REMOVE, 32'd0, 0, 1'b0);
		queue_word(OP_REMOVE, 32'h0000_1234, 0, 1'b0);
		// Fill the store to capacity, then have one insert refused.
		for (k = 0; k < 13; k++)
			queue_word(OP_INSERT, 32'h0101_0101 * k, 0, 1'b0);
		queue_word(OP_INSERT, 32'h5555_5555, 0, 1'b0);

		// Random phases: each biases the operation mix and draws from a small value pool
		// so that duplicates, hits and a full store come up often.
		made = 0;
		while (made < RANDOM_WORDS) begin
			phase_kind = $urandom_range(0, 3);
			case (phase_kind)
				0: begin ins_pct = 70; rem_pct = 15; end
				1: begin ins_pct = 20; rem_pct = 60; end
				2: begin ins_pct = 45; rem_pct = 35; end
				default: begin ins_pct = 30; rem_pct = 20; end
			endcase
			tx_quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < 6; k++) begin
				case ($urandom_range(0, 3))
					0: pool[k] = $urandom();
					1: pool[k] = $urandom_range(0, 1) ? VALUE_TOP : '0;
					default: pool[k] = $urandom_range(0, 12);
				endcase
			end
			for (j = 0; j < 40; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_pct)
					op_code = OP_INSERT;
				else if (roll < ins_pct + rem_pct)
					op_code = OP_REMOVE;
				else
					op_code = ($urandom_range(0, 4) == 0) ? OP_RESERVED : OP_QUERY;
				roll = $urandom_range(0, 9);
				if (roll < 8)
					v = pool[$urandom_range(0, 5)];
				else if (roll == 8)
					v = $urandom();
				else
					v = $urandom_range(0, 1) ? VALUE_TOP - $urandom_range(0, 2) :
						ITEM_BITS'($urandom_range(0, 2));
				gap = (tx_quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, STALL_MAX);
				// The opening word always drains the pipeline; later phases sometimes do.
				queue_word(op_code, v, gap, (made == 0) || (j == 0 && $urandom_range(0, 3) == 0));
				made++;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last request to go out and its response to come back.
		do
			@(negedge clk);
		while (pending_words.size() != 0 || have_next || req.valid || sent_cnt != done_cnt);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch($sformatf("%0d expected responses never arrived",
				expected_rsp.size()));

		if (mismatch_cnt == 0)
			$display("sorted_value_list verification clean");
		else
			$display("sorted_value_list verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/svl_pkg.sv
rtl/svl_if.sv
rtl/svl_cell.sv
rtl/sorted_value_list.sv
bench/sorted_value_list_tb.sv
